// ===== hw/rtl/pctu_pkg.sv =====
`timescale 1ns / 1ps

package pctu_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int NARROW_W   = 8;
    localparam int FRAME_W    = 40;
    localparam int CCOUNT_W   = 4;
    localparam int RATE_W     = 18;
    localparam int SECOND_W   = 16;
    localparam int PRODUCT_W  = RATE_W + SECOND_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [SAMPLE_W-1:0] SIGN_FLIP = 16'h8000;

    localparam logic [CCOUNT_W-1:0] RST_CHANNEL_COUNT = 4'd2;
    localparam logic                RST_WIDE_SAMPLES  = 1'b1;
    localparam logic [RATE_W-1:0]   RST_FRAME_RATE    = 18'd44100;
    localparam logic [SECOND_W-1:0] RST_START_SECOND  = 16'd0;
    localparam logic [SECOND_W-1:0] RST_END_SECOND    = 16'd65535;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT,
        CFG_WIDE_SAMPLES,
        CFG_FRAME_RATE,
        CFG_START_SECOND,
        CFG_END_SECOND
    } t_cfg_idx;

    // controls shared by every cell of the chain
    typedef struct packed {
        logic load;
        logic shift;
        logic wide;
    } t_cell_ctl;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_out;
        logic                interpolated;
        logic                last_out;
        logic                status;
    } t_result;

endpackage

// ===== hw/rtl/pctu_in_if.sv =====
`timescale 1ns / 1ps

interface pctu_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample_in;
    logic        end_of_stream;

    modport source (output valid, output sample_in, output end_of_stream, input ready);
    modport sink (input valid, input sample_in, input end_of_stream, output ready);
endinterface

// ===== hw/rtl/pctu_out_if.sv =====
`timescale 1ns / 1ps

interface pctu_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample_out;
    logic        interpolated;
    logic        last_out;
    logic        status;

    modport source (
        output valid, output sample_out, output interpolated, output last_out,
        output status, input ready
    );
    modport sink (
        input valid, input sample_out, input interpolated, input last_out,
        input status, output ready
    );
endinterface

// ===== hw/rtl/pctu_cell.sv =====
`timescale 1ns / 1ps

module pctu_cell import pctu_pkg::*; (
    input  logic                i_clk,
    input  t_cell_ctl           i_ctl,
    input  logic                i_wr,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [SAMPLE_W-1:0] i_next_burst,
    output logic [SAMPLE_W-1:0] o_prev,
    output logic [SAMPLE_W-1:0] o_burst
);

    logic [SAMPLE_W-1:0] r_cur;
    logic [SAMPLE_W-1:0] r_prev;
    logic [SAMPLE_W-1:0] r_burst;
    logic [SAMPLE_W-1:0] n_cur;
    logic [SAMPLE_W-1:0] n_prev;
    logic [SAMPLE_W-1:0] n_burst;

    always_comb begin
        n_cur   = i_wr ? i_sample : r_cur;
        n_prev  = r_prev;
        n_burst = r_burst;
        if (i_ctl.load) begin
            // frame commit: the incoming sample lands here in the same cycle
            n_prev  = n_cur;
            n_burst = i_ctl.wide ? n_cur : {{(SAMPLE_W-NARROW_W){1'b0}}, n_cur[NARROW_W-1:0]};
        end else if (i_ctl.shift) begin
            n_burst = i_next_burst;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_burst <= n_burst;
    end

    assign o_prev  = r_prev;
    assign o_burst = r_burst;

endmodule

// ===== hw/rtl/pcm_trim_upsample_by_two.sv =====
`timescale 1ns / 1ps

// channel  dir  payload                                         handshake
// i_in     in   sample_in[15:0], end_of_stream                  valid / ready
// o_out    out  sample_out[15:0], interpolated, last_out, status valid / ready
// cfg      in   i_cfg_idx[2:0], i_cfg_data[17:0]                i_cfg_we, never stalls
//
// an accepted sample's midpoint goes straight to the output register
// a kept frame of N channels then drains N originals from the cell chain, one per cycle
// while the output is free; midpoints and originals share the single output register
// input stalls while the chain drains, while a held word fills the output register,
// and in the cycle after reset or a config write (window bounds are registered products)
// reset is synchronous, active low; sample stores in the cells have none

module pcm_trim_upsample_by_two import pctu_pkg::*; #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pctu_in_if.sink               i_in,
    pctu_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
    localparam logic [CCOUNT_W:0] MAX_CNT = (CCOUNT_W + 1)'(MAX_CHANNELS);

    // config
    logic [CCOUNT_W-1:0] r_channel_count;
    logic                r_wide_samples;
    logic [RATE_W-1:0]   r_frame_rate;
    logic [SECOND_W-1:0] r_start_second;
    logic [SECOND_W-1:0] r_end_second;
    logic [PRODUCT_W-1:0] r_first_frame;
    logic [PRODUCT_W-1:0] r_stop_frame;
    logic                r_cfg_busy;

    // stream state
    logic [CH_W-1:0]    r_ch,           n_ch;
    logic [FRAME_W-1:0] r_frame,        n_frame;
    logic               r_have_prev,    n_have_prev;
    logic               r_window_done,  n_window_done;
    logic               r_out_valid,    n_out_valid;
    t_result            r_out,          n_out;
    logic [CNT_W-1:0]   r_burst_cnt,    n_burst_cnt;
    logic               r_burst_last,   n_burst_last;

    logic [CCOUNT_W:0]  cc_ext;
    logic [CH_W-1:0]    cnt_last;
    logic [CH_W-1:0]    ch;
    logic               is_last_ch;
    logic               kept;
    logic               mid;
    logic               burst_load;
    logic               win_hit;
    logic               have_prev_after;
    logic               err;
    logic               mark_last;
    logic               out_free;
    logic               in_ready;
    logic               accept;
    logic               burst_pop;
    logic [SAMPLE_W-1:0] prev_sample;
    logic [SAMPLE_W-1:0] mid_sample;
    logic [SAMPLE_W:0]   sum_wide;
    logic [NARROW_W:0]   sum_narrow;
    t_cell_ctl           cell_ctl;

    logic [SAMPLE_W-1:0] prev_vec  [MAX_CHANNELS];
    logic [SAMPLE_W-1:0] burst_vec [MAX_CHANNELS];

    // config registers and window bounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= RST_CHANNEL_COUNT;
            r_wide_samples  <= RST_WIDE_SAMPLES;
            r_frame_rate    <= RST_FRAME_RATE;
            r_start_second  <= RST_START_SECOND;
            r_end_second    <= RST_END_SECOND;
            r_cfg_busy      <= 1'b1;
        end else begin
            r_cfg_busy <= i_cfg_we;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[CCOUNT_W-1:0];
                    CFG_WIDE_SAMPLES:  r_wide_samples  <= i_cfg_data[0];
                    CFG_FRAME_RATE:    r_frame_rate    <= i_cfg_data[RATE_W-1:0];
                    CFG_START_SECOND:  r_start_second  <= i_cfg_data[SECOND_W-1:0];
                    CFG_END_SECOND:    r_end_second    <= i_cfg_data[SECOND_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_frame <= PRODUCT_W'(r_start_second) * PRODUCT_W'(r_frame_rate);
        r_stop_frame  <= PRODUCT_W'(r_end_second) * PRODUCT_W'(r_frame_rate);
    end

    // effective channel count, clamped to 1..MAX_CHANNELS
    always_comb begin
        cc_ext = {1'b0, r_channel_count};
        if (cc_ext == '0) begin
            cnt_last = '0;
        end else if (cc_ext >= MAX_CNT) begin
            cnt_last = CH_W'(MAX_CHANNELS - 1);
        end else begin
            cnt_last = CH_W'(cc_ext - (CCOUNT_W + 1)'(1));
        end
    end

    assign ch         = (r_ch > cnt_last) ? cnt_last : r_ch;
    assign is_last_ch = (ch == cnt_last);

    assign out_free  = !r_out_valid || o_out.ready;
    assign in_ready  = (r_burst_cnt == '0) && out_free && !r_cfg_busy;
    assign accept    = i_in.valid && in_ready;
    assign burst_pop = (r_burst_cnt != '0) && out_free;

    assign kept = !r_window_done
                  && (r_frame >= FRAME_W'(r_first_frame))
                  && (r_frame < FRAME_W'(r_stop_frame));
    assign mid             = kept && r_have_prev;
    assign burst_load      = kept && is_last_ch;
    assign win_hit         = burst_load
                             && (({1'b0, r_frame} + (FRAME_W + 1)'(1))
                                 >= (FRAME_W + 1)'(r_stop_frame));
    assign have_prev_after = r_have_prev || burst_load;
    assign err             = i_in.end_of_stream && !have_prev_after;
    assign mark_last       = win_hit || i_in.end_of_stream;

    // midpoint against the same channel of the previous kept frame
    assign prev_sample = prev_vec[ch];
    always_comb begin
        sum_wide   = {1'b0, prev_sample ^ SIGN_FLIP} + {1'b0, i_in.sample_in ^ SIGN_FLIP};
        sum_narrow = {1'b0, prev_sample[NARROW_W-1:0]} + {1'b0, i_in.sample_in[NARROW_W-1:0]};
        if (r_wide_samples) begin
            mid_sample = sum_wide[SAMPLE_W:1] ^ SIGN_FLIP;
        end else begin
            mid_sample = {{(SAMPLE_W-NARROW_W){1'b0}}, sum_narrow[NARROW_W:1]};
        end
    end

    assign cell_ctl.load  = accept && burst_load;
    assign cell_ctl.shift = burst_pop;
    assign cell_ctl.wide  = r_wide_samples;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_CHANNELS; gi++) begin : g_cell
            logic [SAMPLE_W-1:0] next_burst;
            if (gi == MAX_CHANNELS - 1) begin : g_tail
                assign next_burst = '0;
            end else begin : g_link
                assign next_burst = burst_vec[gi + 1];
            end
            pctu_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (cell_ctl),
                .i_wr         (accept && (ch == CH_W'(gi))),
                .i_sample     (i_in.sample_in),
                .i_next_burst (next_burst),
                .o_prev       (prev_vec[gi]),
                .o_burst      (burst_vec[gi])
            );
        end
    endgenerate

    always_comb begin
        n_ch          = r_ch;
        n_frame       = r_frame;
        n_have_prev   = r_have_prev;
        n_window_done = r_window_done;
        n_out_valid   = r_out_valid;
        n_out         = r_out;
        n_burst_cnt   = r_burst_cnt;
        n_burst_last  = r_burst_last;

        if (accept) begin
            if (i_in.end_of_stream) begin
                n_ch          = '0;
                n_frame       = '0;
                n_have_prev   = 1'b0;
                n_window_done = 1'b0;
            end else begin
                n_ch          = is_last_ch ? '0 : ch + CH_W'(1);
                n_frame       = is_last_ch ? r_frame + FRAME_W'(1) : r_frame;
                n_have_prev   = have_prev_after;
                n_window_done = r_window_done || win_hit;
            end
            if (burst_load) begin
                n_burst_cnt  = CNT_W'(cnt_last) + CNT_W'(1);
                n_burst_last = mark_last;
            end
        end else if (burst_pop) begin
            n_burst_cnt = r_burst_cnt - CNT_W'(1);
        end

        if (accept && (mid || err)) begin
            n_out_valid        = 1'b1;
            n_out.sample_out   = mid ? mid_sample : '0;
            n_out.interpolated = mid;
            n_out.last_out     = mark_last && !burst_load;
            n_out.status       = !mid;
        end else if (burst_pop) begin
            n_out_valid        = 1'b1;
            n_out.sample_out   = burst_vec[0];
            n_out.interpolated = 1'b0;
            n_out.last_out     = r_burst_last && (r_burst_cnt == CNT_W'(1));
            n_out.status       = 1'b0;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch          <= '0;
            r_frame       <= '0;
            r_have_prev   <= 1'b0;
            r_window_done <= 1'b0;
            r_out_valid   <= 1'b0;
            r_burst_cnt   <= '0;
            r_burst_last  <= 1'b0;
        end else begin
            r_ch          <= n_ch;
            r_frame       <= n_frame;
            r_have_prev   <= n_have_prev;
            r_window_done <= n_window_done;
            r_out_valid   <= n_out_valid;
            r_burst_cnt   <= n_burst_cnt;
            r_burst_last  <= n_burst_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign i_in.ready         = in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.sample_out   = r_out.sample_out;
    assign o_out.interpolated = r_out.interpolated;
    assign o_out.last_out     = r_out.last_out;
    assign o_out.status       = r_out.status;

endmodule

// ===== hw/rtl/pctu_checker.sv =====
`timescale 1ns / 1ps

module pctu_checker import pctu_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [SAMPLE_W-1:0] i_sample_out,
    input logic                i_interpolated,
    input logic                i_last_out,
    input logic                i_status,
    input logic                i_cfg_we
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable(i_sample_out) && $stable(i_interpolated)
            && $stable(i_last_out) && $stable(i_status))
        else $error("output word changed while stalled");

    // the error word is a lone marked zero
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status |-> i_last_out && !i_interpolated && (i_sample_out == '0))
        else $error("malformed error word");

    // window bounds are re-registered after a config write
    a_cfg_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !(i_in_valid && i_in_ready))
        else $error("input taken before window bounds settled");

    // the input side never takes a word while the output stalls a full register
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input accepted over a stalled output");

endmodule

bind pcm_trim_upsample_by_two pctu_checker u_pctu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_sample_out   (o_out.sample_out),
    .i_interpolated (o_out.interpolated),
    .i_last_out     (o_out.last_out),
    .i_status       (o_out.status),
    .i_cfg_we       (i_cfg_we)
);
